@@ src/dcbt_pkg.sv @@
package dcbt_pkg;

    localparam int NUM_CHUNKS_DEF  = 64;
    localparam int CHUNK_BYTES_DEF = 64;

    localparam int ADDR_W    = 12;
    localparam int REQ_W     = 2;
    localparam int IDX_W     = 6;
    localparam int ROW_BITS  = 8;
    localparam int BIT_W     = 3;

    localparam logic [REQ_W-1:0] REQ_MARK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESTORE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_EMIT,
        S_EMPTY
    } scan_state_t;

    typedef struct packed {
        logic busy;
        logic clear_all;
    } scan_ctrl_t;

    typedef struct packed {
        logic restore_go;
        logic restore_pending;
    } upd_status_t;

endpackage

@@ src/dcbt_ram.sv @@
module dcbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/dcbt_update.sv @@
module dcbt_update
    import dcbt_pkg::*;
#(
    parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    localparam int ROWS  = NUM_CHUNKS / ROW_BITS,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                acc,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [ADDR_W-1:0]   address,
    input  scan_ctrl_t          sc,
    input  logic [ROW_BITS-1:0] rdata,
    output logic [ROW_W-1:0]    raddr,
    output logic                we,
    output logic [ROW_W-1:0]    waddr,
    output logic [ROW_BITS-1:0] wdata,
    output logic [ROWS-1:0]     row_valid,
    output upd_status_t         st
);

    localparam int CB_SH  = $clog2(CHUNK_BYTES);
    localparam int CIDX_W = $clog2(NUM_CHUNKS);

    logic [ADDR_W-1:0]   chunk_full;
    logic [CIDX_W-1:0]   chunk;

    logic                p_valid_reg;
    logic [REQ_W-1:0]    p_type_reg;
    logic [ROW_W-1:0]    p_row_reg;
    logic [BIT_W-1:0]    p_bit_reg;

    logic [ROWS-1:0]     valid_reg, valid_next;
    logic                fwd_valid_reg;
    logic [ROW_W-1:0]    fwd_row_reg;
    logic [ROW_BITS-1:0] fwd_data_reg;

    logic [ROW_BITS-1:0] old_row;
    logic [ROW_BITS-1:0] new_row;

    // drop bits above the area, keep the chunk number
    assign chunk_full = address >> CB_SH;
    assign chunk      = chunk_full[CIDX_W-1:0];
    assign raddr      = ROW_W'(chunk >> BIT_W);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= acc;
        end
        p_type_reg <= req_type;
        p_row_reg  <= raddr;
        p_bit_reg  <= chunk[BIT_W-1:0];
    end

    // a row written at the edge of this read returns stale data: forward it
    always_comb begin
        if (!valid_reg[p_row_reg]) begin
            old_row = '0;
        end else if (fwd_valid_reg && fwd_row_reg == p_row_reg) begin
            old_row = fwd_data_reg;
        end else begin
            old_row = rdata;
        end
    end

    assign new_row = old_row | (ROW_BITS'(1) << p_bit_reg);
    assign we      = p_valid_reg && p_type_reg == REQ_MARK;
    assign waddr   = p_row_reg;
    assign wdata   = new_row;

    always_comb begin
        valid_next = valid_reg;
        if (sc.clear_all || (p_valid_reg && p_type_reg == REQ_CLEAR)) begin
            valid_next = '0;
        end else if (we) begin
            valid_next[p_row_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            fwd_valid_reg <= we;
        end
        fwd_row_reg  <= p_row_reg;
        fwd_data_reg <= new_row;
    end

    assign row_valid          = valid_reg;
    assign st.restore_go      = p_valid_reg && p_type_reg == REQ_RESTORE;
    assign st.restore_pending = p_valid_reg && p_type_reg == REQ_RESTORE;

`ifndef SYNTHESIS
    a_mark_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && !sc.clear_all) |=> valid_reg[$past(p_row_reg)])
        else $error("mark did not set row valid");
`endif

endmodule

@@ src/dcbt_scan.sv @@
module dcbt_scan
    import dcbt_pkg::*;
#(
    parameter int NUM_CHUNKS = NUM_CHUNKS_DEF,
    localparam int ROWS  = NUM_CHUNKS / ROW_BITS,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [ROWS-1:0]     row_valid,
    input  logic [ROW_BITS-1:0] rdata,
    output logic [ROW_W-1:0]    raddr,
    output scan_ctrl_t          sc,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [IDX_W-1:0]    m_idx,
    output logic                m_cv,
    output logic                m_last
);

    scan_state_t         state_reg, state_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ROW_BITS-1:0] word_reg, word_next;

    logic [ROW_W-1:0]    first_row, next_row;
    logic                any_valid, any_above;
    logic [BIT_W-1:0]    lowb;
    logic                single;
    logic                slot_free;

    logic                emit;
    logic [IDX_W-1:0]    emit_idx;
    logic                emit_cv;
    logic                emit_last;

    logic                m_valid_reg;
    logic [IDX_W-1:0]    m_idx_reg;
    logic                m_cv_reg;
    logic                m_last_reg;

    always_comb begin
        first_row = '0;
        next_row  = '0;
        any_valid = 1'b0;
        any_above = 1'b0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (row_valid[i]) begin
                first_row = ROW_W'(i);
                any_valid = 1'b1;
                if (ROW_W'(i) > row_reg) begin
                    next_row  = ROW_W'(i);
                    any_above = 1'b1;
                end
            end
        end
    end

    always_comb begin
        lowb = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (word_reg[i]) begin
                lowb = BIT_W'(i);
            end
        end
    end

    assign single    = (word_reg & (word_reg - ROW_BITS'(1))) == '0;
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        word_next  = word_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    row_next   = first_row;
                    state_next = any_valid ? S_RD : S_EMPTY;
                end
            end
            S_RD: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                word_next  = rdata;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    word_next = word_reg & ~(ROW_BITS'(1) << lowb);
                    if (single) begin
                        if (any_above) begin
                            row_next   = next_row;
                            state_next = S_RD;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_EMPTY: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        emit         = 1'b0;
        emit_idx     = '0;
        emit_cv      = 1'b0;
        emit_last    = 1'b0;
        sc.busy      = state_reg != S_IDLE;
        sc.clear_all = 1'b0;
        case (state_reg)
            S_EMIT: begin
                emit         = slot_free;
                emit_idx     = IDX_W'({row_reg, lowb});
                emit_cv      = 1'b1;
                emit_last    = single && !any_above;
                sc.clear_all = slot_free && single && !any_above;
            end
            S_EMPTY: begin
                emit         = slot_free;
                emit_last    = 1'b1;
                sc.clear_all = slot_free;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign raddr = row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        row_reg  <= row_next;
        word_reg <= word_next;
        if (emit) begin
            m_idx_reg  <= emit_idx;
            m_cv_reg   <= emit_cv;
            m_last_reg <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_idx   = m_idx_reg;
    assign m_cv    = m_cv_reg;
    assign m_last  = m_last_reg;

`ifndef SYNTHESIS
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (word_reg != '0))
        else $error("emit state with empty row word");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == S_IDLE))
        else $error("restore started while scanning");
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        sc.clear_all |=> (row_valid == '0 && state_reg == S_IDLE))
        else $error("bitmap not cleared after final result");
`endif

endmodule

@@ src/dirty_chunk_bitmap_tracker_unit.sv @@
// Mark and clear requests: one per cycle while no restore is pending or running, no result;
// a mark is a read-modify-write of the row memory, with forwarding between back-to-back marks.
// Restore: after a start strobe, each dirty row is read through S_RD and S_LOAD, then one
// result per dirty chunk is given per cycle while m_axis_tready holds; with nothing dirty,
// a single result. No request is taken while a restore runs.
// Reset (aresetn low, synchronous) clears all row valid flags, so the bitmap reads as zeros.
module dirty_chunk_bitmap_tracker_unit
    import dcbt_pkg::*;
#(
    parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] address
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] chunk_index
    output logic        m_axis_tuser,   // [0] chunk_valid
    output logic        m_axis_tlast
);

    localparam int ROWS  = NUM_CHUNKS / ROW_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    scan_ctrl_t          sc;
    upd_status_t         st;
    logic                acc;
    logic [ROW_W-1:0]    mark_raddr, scan_raddr, raddr;
    logic                we;
    logic [ROW_W-1:0]    waddr;
    logic [ROW_BITS-1:0] wdata, rdata;
    logic [ROWS-1:0]     row_valid;
    logic [IDX_W-1:0]    m_idx;

    assign s_axis_tready = !sc.busy && !st.restore_pending;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign raddr         = sc.busy ? scan_raddr : mark_raddr;

    dcbt_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(ROWS)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    dcbt_update #(
        .NUM_CHUNKS (NUM_CHUNKS),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_update (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc      (acc),
        .req_type (s_axis_tuser),
        .address  (s_axis_tdata[ADDR_W-1:0]),
        .sc       (sc),
        .rdata    (rdata),
        .raddr    (mark_raddr),
        .we       (we),
        .waddr    (waddr),
        .wdata    (wdata),
        .row_valid(row_valid),
        .st       (st)
    );

    dcbt_scan #(
        .NUM_CHUNKS(NUM_CHUNKS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (st.restore_go),
        .row_valid(row_valid),
        .rdata    (rdata),
        .raddr    (scan_raddr),
        .sc       (sc),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_idx    (m_idx),
        .m_cv     (m_axis_tuser),
        .m_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, m_idx};

endmodule
